// ===== rtl/ezs_pkg.sv =====
`default_nettype none
package ezs_pkg;

  // Fixed field widths
  localparam int unsigned NumChannels = 6;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned ValW        = 32;
  localparam int unsigned VarW        = 64;
  localparam int unsigned AlphaW      = 16;
  localparam int unsigned ScoreW      = 16;
  localparam int unsigned ThrW        = 15;
  localparam int unsigned CntW        = 8;
  localparam int unsigned FracBits    = 8;

  // Variance floor: round(1e-4 * 2^(2*FracBits)), at least one
  localparam logic [VarW-1:0] VarFloorRaw =
    ((64'd1 << (2 * FracBits)) + 64'd5000) / 64'd10000;
  localparam logic [VarW-1:0] VarFloor = (VarFloorRaw == '0) ? 64'd1 : VarFloorRaw;

  // Configuration register indexes
  localparam logic [2:0] CfgAlphaPacketRate = 3'd0;
  localparam logic [2:0] CfgAlphaByteRate   = 3'd1;
  localparam logic [2:0] CfgAlphaConns      = 3'd2;
  localparam logic [2:0] CfgAlphaNewConns   = 3'd3;
  localparam logic [2:0] CfgAlphaEntropy    = 3'd4;
  localparam logic [2:0] CfgAlphaAvgSize    = 3'd5;
  localparam logic [2:0] CfgThreshold       = 3'd6;
  localparam logic [2:0] CfgWarmup          = 3'd7;

  localparam logic [AlphaW-1:0] AlphaReset [NumChannels] =
    '{16'd9830, 16'd9830, 16'd7864, 16'd7864, 16'd6554, 16'd6554};
  localparam logic [ThrW-1:0] ThresholdReset = 15'd717;
  localparam logic [CntW-1:0] WarmupReset    = 8'd6;

  // Action codes
  localparam logic ActUpdate = 1'b0;
  localparam logic ActClear  = 1'b1;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [ValW-1:0]   mag;
    logic [ValW-1:0]   mean;
    logic [VarW-1:0]   variance;
    logic [AlphaW-1:0] alpha;
  } ezs_req_t;

  typedef struct packed {
    logic              done;
    logic [ValW-1:0]   mean;
    logic [VarW-1:0]   variance;
    logic [ScoreW-1:0] qmag;
  } ezs_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ezs_core.sv =====
`default_nettype none
// Iterative statistics engine: bit-serial square root, restoring divide,
// then mean and variance update through one shared 32x32 multiplier.
module ezs_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ezs_pkg::ezs_req_t req_i,
  output ezs_pkg::ezs_rsp_t    rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_DIV, S_MSTEP, S_MSQ, S_QLO, S_QHI, S_QSUM, S_ADD, S_DONE
  } state_e;

  state_e       state_q;
  logic [5:0]   cnt_q;
  logic         neg_q, phase_q;
  logic [31:0]  mag_q, mean_q, root_q, drem_q;
  logic [63:0]  var_q, v_q, x_q, t_q, var_new_q;
  logic [15:0]  alpha_q, qmag_q;
  logic [34:0]  rem_q;
  logic [39:0]  num_q, quot_q;
  logic [47:0]  p_q;
  logic [16:0]  k_q;
  logic [48:0]  lo_q, hi_q;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [34:0]  rem_n, trial;
  logic         sq_ge;
  logic [32:0]  dr_n;
  logic         dv_ge;
  logic [80:0]  qsum;
  logic [63:0]  qres;
  logic [64:0]  vsum;
  logic [39:0]  qmax;
  logic [31:0]  step;

  // Select operands of the shared multiplier
  always_comb begin
    unique case (state_q)
      S_MSTEP: begin
        mul_a = mag_q;
        mul_b = {16'd0, alpha_q};
      end
      S_MSQ: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
      S_QLO: begin
        mul_a = x_q[31:0];
        mul_b = {15'd0, k_q};
      end
      S_QHI: begin
        mul_a = x_q[63:32];
        mul_b = {15'd0, k_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Square root digit step and divide step
  assign rem_n = {rem_q[32:0], v_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sq_ge = (rem_n >= trial);
  assign dr_n  = {drem_q, num_q[39]};
  assign dv_ge = (dr_n >= {1'b0, root_q});

  assign qsum = {hi_q, 32'd0} + {32'd0, lo_q};
  assign qres = qsum[79:16];
  assign vsum = {1'b0, var_q} + {1'b0, t_q};
  assign qmax = neg_q ? 40'd32768 : 40'd32767;
  assign step = p_q[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      neg_q     <= 1'b0;
      phase_q   <= 1'b0;
      mag_q     <= '0;
      mean_q    <= '0;
      root_q    <= '0;
      drem_q    <= '0;
      var_q     <= '0;
      v_q       <= '0;
      x_q       <= '0;
      t_q       <= '0;
      var_new_q <= '0;
      alpha_q   <= '0;
      qmag_q    <= '0;
      rem_q     <= '0;
      num_q     <= '0;
      quot_q    <= '0;
      p_q       <= '0;
      k_q       <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            neg_q   <= req_i.neg;
            mag_q   <= req_i.mag;
            mean_q  <= req_i.mean;
            var_q   <= req_i.variance;
            alpha_q <= req_i.alpha;
            v_q     <= (req_i.variance > ezs_pkg::VarFloor) ? req_i.variance
                                                            : ezs_pkg::VarFloor;
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= 6'd31;
            state_q <= S_SQRT;
          end
        end
        // Two radicand bits per cycle
        S_SQRT: begin
          v_q <= {v_q[61:0], 2'b00};
          if (sq_ge) begin
            rem_q  <= rem_n - trial;
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= rem_n;
            root_q <= {root_q[30:0], 1'b0};
          end
          if (cnt_q == '0) begin
            num_q   <= {mag_q, 8'd0};
            drem_q  <= '0;
            quot_q  <= '0;
            cnt_q   <= 6'd39;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        // One quotient bit per cycle
        S_DIV: begin
          num_q <= {num_q[38:0], 1'b0};
          if (dv_ge) begin
            drem_q <= 32'(dr_n - {1'b0, root_q});
            quot_q <= {quot_q[38:0], 1'b1};
          end else begin
            drem_q <= dr_n[31:0];
            quot_q <= {quot_q[38:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= S_MSTEP;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_MSTEP: begin
          qmag_q  <= (quot_q > qmax) ? qmax[15:0] : quot_q[15:0];
          p_q     <= mul_p[47:0];
          state_q <= S_MSQ;
        end
        // Apply mean step, square the deviation
        S_MSQ: begin
          mean_q  <= neg_q ? (mean_q - step) : (mean_q + step);
          x_q     <= mul_p;
          k_q     <= {1'b0, alpha_q};
          phase_q <= 1'b0;
          state_q <= S_QLO;
        end
        S_QLO: begin
          lo_q    <= mul_p[48:0];
          state_q <= S_QHI;
        end
        S_QHI: begin
          hi_q    <= mul_p[48:0];
          state_q <= S_QSUM;
        end
        S_QSUM: begin
          if (phase_q) begin
            var_new_q <= qres;
            state_q   <= S_DONE;
          end else begin
            t_q     <= qres;
            state_q <= S_ADD;
          end
        end
        // Saturating sum, then scale by one minus alpha
        S_ADD: begin
          x_q     <= vsum[64] ? '1 : vsum[63:0];
          k_q     <= 17'h10000 - {1'b0, alpha_q};
          phase_q <= 1'b1;
          state_q <= S_QLO;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done     = (state_q == S_DONE);
  assign rsp_o.mean     = mean_q;
  assign rsp_o.variance = var_new_q;
  assign rsp_o.qmag     = qmag_q;

endmodule
`default_nettype wire

// ===== rtl/ewma_zscore_anomaly_scorer_unit.sv =====
`default_nettype none
// EWMA z-score anomaly scorer for six metric channels.
// Input stream (s_axis): one transaction either updates a channel with a
// sample or clears it; the action travels in tuser. Every input transaction
// gives exactly one result transaction on m_axis: channel, Q7.8 score,
// anomaly and warmup flags.
// Config channel (cfg_*): writes one register by index; always ready and
// meant to be used only while the block is idle.
// A scored update runs the 32-step square root and the 40-step restoring
// divide in the core, then nine multiply/add steps on its shared
// multiplier, with start, hand-back and output steps around them.
// Clear, first-sample and out-of-range items skip the core: their result
// goes to the hold state, then into the output register.
// One item is in flight at a time; s_axis_tready is low until its result
// has been moved into the output register, so no new item is taken
// before the last one is through.
// Reset sets all channels to unseeded, mean 0, variance at the floor, and
// the registers to their defaults. On a receiver stall the result holds in
// the output register; one more item is taken and its result waits in hold.
module ewma_zscore_anomaly_scorer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // channel[2:0], sample[34:3], zero pad
  input  wire logic        s_axis_tuser,  // action[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // channel_out[2:0], score[18:3], zero pad
  output logic [1:0]       m_axis_tuser,  // anomaly[0], in_warmup[1]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_e;

  localparam int unsigned N = ezs_pkg::NumChannels;

  state_e                       state_q;
  logic [ezs_pkg::AlphaW-1:0]   alpha_q [N];
  logic [ezs_pkg::ThrW-1:0]     thr_q;
  logic [ezs_pkg::CntW-1:0]     warmup_q;
  logic [ezs_pkg::ValW-1:0]     mean_q [N];
  logic [ezs_pkg::VarW-1:0]     var_q [N];
  logic [ezs_pkg::CntW-1:0]     cnt_q [N];
  logic [N-1:0]                 seeded_q;

  ezs_pkg::ezs_req_t            req_q;
  ezs_pkg::ezs_rsp_t            rsp;
  logic [2:0]                   ch_q;
  logic                         warm_q;

  logic [2:0]                   res_ch_q;
  logic [15:0]                  res_score_q;
  logic                         res_anom_q, res_warm_q;

  logic [2:0]                   in_ch, ch_idx;
  logic [31:0]                  in_sample, cur_mean;
  logic                         in_act, in_range, accept;
  logic [15:0]                  score_n;
  logic                         anom_n;
  logic                         out_load, start_n;

  assign in_ch     = s_axis_tdata[2:0];
  assign in_sample = s_axis_tdata[34:3];
  assign in_act    = s_axis_tuser;
  assign in_range  = (in_ch < 3'(N));
  assign ch_idx    = in_range ? in_ch : 3'd0;
  assign cur_mean  = mean_q[ch_idx];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Load the output register when a result waits and the register is free
  assign out_load = (state_q == ST_HOLD) && (!m_axis_tvalid || m_axis_tready);
  // Start the core only for an update of a seeded channel
  assign start_n  = accept && in_range && (in_act == ezs_pkg::ActUpdate) &&
                    seeded_q[ch_idx];

  // Signed score and anomaly flag from the core's saturated magnitude
  assign score_n = warm_q ? '0 : (req_q.neg ? (~rsp.qmag + 16'd1) : rsp.qmag);
  assign anom_n  = !warm_q && ({1'b0, rsp.qmag} > {2'b00, thr_q});

  ezs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) alpha_q[i] <= ezs_pkg::AlphaReset[i];
      thr_q    <= ezs_pkg::ThresholdReset;
      warmup_q <= ezs_pkg::WarmupReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ezs_pkg::CfgAlphaPacketRate: alpha_q[0] <= cfg_data_i;
        ezs_pkg::CfgAlphaByteRate:   alpha_q[1] <= cfg_data_i;
        ezs_pkg::CfgAlphaConns:      alpha_q[2] <= cfg_data_i;
        ezs_pkg::CfgAlphaNewConns:   alpha_q[3] <= cfg_data_i;
        ezs_pkg::CfgAlphaEntropy:    alpha_q[4] <= cfg_data_i;
        ezs_pkg::CfgAlphaAvgSize:    alpha_q[5] <= cfg_data_i;
        ezs_pkg::CfgThreshold:       thr_q      <= cfg_data_i[14:0];
        ezs_pkg::CfgWarmup:          warmup_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer, channel statistics and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      for (int i = 0; i < N; i++) begin
        mean_q[i] <= '0;
        var_q[i]  <= ezs_pkg::VarFloor;
        cnt_q[i]  <= '0;
      end
      seeded_q      <= '0;
      req_q         <= '0;
      ch_q          <= '0;
      warm_q        <= 1'b0;
      res_ch_q      <= '0;
      res_score_q   <= '0;
      res_anom_q    <= 1'b0;
      res_warm_q    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= '0;
    end else begin
      req_q.start <= start_n;
      // Hold the result until taken, then drop valid
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {5'd0, res_score_q, res_ch_q};
        m_axis_tuser  <= {res_warm_q, res_anom_q};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ch_q        <= in_ch;
            res_ch_q    <= in_ch;
            res_score_q <= '0;
            res_anom_q  <= 1'b0;
            if (!in_range) begin
              // no state change
              res_warm_q <= 1'b0;
              state_q    <= ST_HOLD;
            end else if (in_act == ezs_pkg::ActClear) begin
              mean_q[ch_idx]   <= '0;
              var_q[ch_idx]    <= ezs_pkg::VarFloor;
              cnt_q[ch_idx]    <= '0;
              seeded_q[ch_idx] <= 1'b0;
              res_warm_q       <= 1'b0;
              state_q          <= ST_HOLD;
            end else if (!seeded_q[ch_idx]) begin
              mean_q[ch_idx]   <= in_sample;
              var_q[ch_idx]    <= ezs_pkg::VarFloor;
              cnt_q[ch_idx]    <= 8'd1;
              seeded_q[ch_idx] <= 1'b1;
              res_warm_q       <= 1'b1;
              state_q          <= ST_HOLD;
            end else begin
              req_q.neg      <= (in_sample < cur_mean);
              req_q.mag      <= (in_sample < cur_mean) ? (cur_mean - in_sample)
                                                       : (in_sample - cur_mean);
              req_q.mean     <= cur_mean;
              req_q.variance <= var_q[ch_idx];
              req_q.alpha    <= alpha_q[ch_idx];
              warm_q         <= (cnt_q[ch_idx] < warmup_q);
              state_q        <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (rsp.done) begin
            mean_q[ch_q] <= rsp.mean;
            var_q[ch_q]  <= rsp.variance;
            if (cnt_q[ch_q] != 8'hFF) cnt_q[ch_q] <= cnt_q[ch_q] + 8'd1;
            res_score_q  <= score_n;
            res_anom_q   <= anom_n;
            res_warm_q   <= warm_q;
            state_q      <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // Move the result once the output register is free
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A core result only arrives while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == ST_RUN)
    else $error("core result outside run state");

  // A start pulse only follows an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.start |-> $past(accept) && state_q == ST_RUN)
    else $error("core start without accepted item");

  // Every accepted item leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item dropped");

  // A warmup result never flags an anomaly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata[18:3] == '0)
    else $error("anomaly flagged during warmup");

endmodule
`default_nettype wire

// ===== bench/ewma_zscore_anomaly_scorer_unit_tb.sv =====
module ewma_zscore_anomaly_scorer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ezs_pkg::ChanW-1:0]  chan;
    logic [ezs_pkg::ScoreW-1:0] score;
    logic                       anomaly;
    logic                       warm;
  } score_res_t;

  typedef struct {
    logic                      act;
    logic [ezs_pkg::ChanW-1:0] chan;
    logic [ezs_pkg::ValW-1:0]  sample;
    logic                      has_res;
    score_res_t                res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  ewma_zscore_anomaly_scorer_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the channel statistics and registers
  logic [ezs_pkg::AlphaW-1:0] alpha_q [ezs_pkg::NumChannels];
  logic [ezs_pkg::ThrW-1:0]   thresh_q;
  logic [ezs_pkg::CntW-1:0]   warmup_q;
  logic [ezs_pkg::ValW-1:0]   mean_q [ezs_pkg::NumChannels];
  logic [ezs_pkg::VarW-1:0]   var_q [ezs_pkg::NumChannels];
  logic [ezs_pkg::CntW-1:0]   count_q [ezs_pkg::NumChannels];
  logic                       seeded_q [ezs_pkg::NumChannels];

  score_res_t pending_scores[$];
  int errors = 0;
  int n_results = 0;
  int n_anomaly = 0;
  int n_scored = 0;
  bit hold_off = 1'b0;
  bit long_stall_req = 1'b0;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [ezs_pkg::VarW-1:0] frac_mul(
      input logic [ezs_pkg::VarW-1:0] x, input logic [16:0] k);
    logic [ezs_pkg::VarW+16:0] p;
    p = x * k;
    return p[ezs_pkg::VarW+15:16];
  endfunction

  function automatic logic [ezs_pkg::VarW-1:0] int_sqrt(input logic [ezs_pkg::VarW-1:0] v);
    logic [ezs_pkg::VarW-1:0] r;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      logic [ezs_pkg::VarW-1:0] t;
      t = r | (64'd1 << b);
      if (t * t <= v && t < 64'h1_0000_0000) r = t;
    end
    return r;
  endfunction

  function automatic void clear_stats(input int c);
    mean_q[c] = '0;
    var_q[c] = ezs_pkg::VarFloor;
    count_q[c] = '0;
    seeded_q[c] = 1'b0;
  endfunction

  function automatic void reset_shadow();
    for (int c = 0; c < ezs_pkg::NumChannels; c++) begin
      alpha_q[c] = ezs_pkg::AlphaReset[c];
      clear_stats(c);
    end
    thresh_q = ezs_pkg::ThresholdReset;
    warmup_q = ezs_pkg::WarmupReset;
  endfunction

  // Score one item and advance the channel statistics
  function automatic score_res_t score_item(input logic act,
                                            input logic [ezs_pkg::ChanW-1:0] ch,
                                            input logic [ezs_pkg::ValW-1:0] smp);
    score_res_t r;
    logic neg;
    logic [ezs_pkg::ValW-1:0] mag, step;
    logic [ezs_pkg::VarW-1:0] sd, q, d2, t, s, v, step64;
    logic [ezs_pkg::VarW:0] sum;
    logic [ezs_pkg::CntW-1:0] old;
    r = '0;
    r.chan = ch;
    if (ch >= ezs_pkg::NumChannels) return r;
    if (act == ezs_pkg::ActClear) begin
      clear_stats(ch);
    end else if (!seeded_q[ch]) begin
      seeded_q[ch] = 1'b1;
      mean_q[ch] = smp;
      var_q[ch] = ezs_pkg::VarFloor;
      count_q[ch] = 8'd1;
      r.warm = 1'b1;
    end else begin
      v = var_q[ch];
      neg = smp < mean_q[ch];
      mag = neg ? mean_q[ch] - smp : smp - mean_q[ch];
      sd = int_sqrt(v > ezs_pkg::VarFloor ? v : ezs_pkg::VarFloor);
      if (sd == '0) sd = 64'd1;
      q = {24'd0, mag, 8'd0} / sd;
      if (neg) begin
        if (q > 64'd32768) q = 64'd32768;
        r.score = -q[15:0];
      end else begin
        if (q > 64'd32767) q = 64'd32767;
        r.score = q[15:0];
      end
      step64 = frac_mul({32'd0, mag}, {1'b0, alpha_q[ch]});
      step = step64[ezs_pkg::ValW-1:0];
      mean_q[ch] = neg ? mean_q[ch] - step : mean_q[ch] + step;
      d2 = mag * mag;
      t = frac_mul(d2, {1'b0, alpha_q[ch]});
      sum = {1'b0, v} + t;
      s = sum[ezs_pkg::VarW] ? '1 : sum[ezs_pkg::VarW-1:0];
      var_q[ch] = frac_mul(s, 17'h10000 - alpha_q[ch]);
      // Warmup is judged on the count before this sample
      old = count_q[ch];
      if (old != 8'd255) count_q[ch] = old + 8'd1;
      if (old < warmup_q) begin
        r.score = '0;
        q = '0;
        r.warm = 1'b1;
      end
      if (q > thresh_q) r.anomaly = 1'b1;
    end
    return r;
  endfunction

  // Random gap: mostly short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(150, 20);
  endfunction

  // Offer one register write; valid stays up for the next write, the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < ezs_pkg::NumChannels) alpha_q[idx] = val;
    else if (idx == ezs_pkg::CfgThreshold) thresh_q = val[ezs_pkg::ThrW-1:0];
    else warmup_q = val[ezs_pkg::CntW-1:0];
  endtask

  // Offer one item, wait for acceptance, record its expectation
  task automatic send_item(input logic act, input logic [ezs_pkg::ChanW-1:0] ch,
                           input logic [ezs_pkg::ValW-1:0] smp, input bit may_gap);
    int g;
    g = may_gap ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata <= {5'd0, smp, ch};
    s_axis_tuser <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_scores.push_back(score_item(act, ch, smp));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        m_axis_tready <= 1'b0;
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
        long_stall_req = 1'b0;
      end else begin
        g = hold_off ? 0 : pick_gap();
        if (g > 0 && $urandom_range(1)) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    score_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_scores.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata[2:0] !== want.chan)
          report($sformatf("channel %0d want %0d", m_axis_tdata[2:0], want.chan));
        if (m_axis_tdata[18:3] !== want.score)
          report($sformatf("score %h want %h (ch %0d)", m_axis_tdata[18:3], want.score,
                           want.chan));
        if (m_axis_tuser[0] !== want.anomaly)
          report($sformatf("anomaly %b want %b", m_axis_tuser[0], want.anomaly));
        if (m_axis_tuser[1] !== want.warm)
          report($sformatf("warmup %b want %b", m_axis_tuser[1], want.warm));
        if (m_axis_tuser[0] === 1'b1) n_anomaly++;
        if (want.warm == 1'b0 && want.score != 0) n_scored++;
      end
    end
  end

  initial begin
    #50ms;
    $display("ewma_zscore_anomaly_scorer_unit test failed");
    $finish;
  end

  // Directed table: expected values only where they are obvious
  stim_row_t dir_rows [] = '{
    '{ezs_pkg::ActUpdate, 3'd6, 32'hFFFF_FFFF, 1'b1, '{3'd6, 16'd0, 1'b0, 1'b0}},
    '{ezs_pkg::ActUpdate, 3'd7, 32'h0, 1'b1, '{3'd7, 16'd0, 1'b0, 1'b0}},
    '{ezs_pkg::ActClear, 3'd0, 32'h0, 1'b1, '{3'd0, 16'd0, 1'b0, 1'b0}},
    '{ezs_pkg::ActUpdate, 3'd0, 32'h0, 1'b1, '{3'd0, 16'd0, 1'b0, 1'b1}},
    '{ezs_pkg::ActUpdate, 3'd1, 32'hFFFF_FFFF, 1'b1, '{3'd1, 16'd0, 1'b0, 1'b1}},
    '{ezs_pkg::ActUpdate, 3'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ezs_pkg::ActUpdate, 3'd1, 32'h0, 1'b0, '0},
    '{ezs_pkg::ActUpdate, 3'd0, 32'h0, 1'b0, '0},
    '{ezs_pkg::ActUpdate, 3'd1, 32'hFFFF_FFFF, 1'b0, '0},
    '{ezs_pkg::ActClear, 3'd1, 32'hFFFF_FFFF, 1'b1, '{3'd1, 16'd0, 1'b0, 1'b0}},
    '{ezs_pkg::ActUpdate, 3'd2, 32'h0000_0100, 1'b1, '{3'd2, 16'd0, 1'b0, 1'b1}},
    '{ezs_pkg::ActUpdate, 3'd2, 32'h0000_0100, 1'b0, '0},
    '{ezs_pkg::ActUpdate, 3'd2, 32'h0000_0101, 1'b0, '0},
    '{ezs_pkg::ActUpdate, 3'd3, 32'h5555_5555, 1'b1, '{3'd3, 16'd0, 1'b0, 1'b1}},
    '{ezs_pkg::ActUpdate, 3'd3, 32'hAAAA_AAAA, 1'b0, '0},
    '{ezs_pkg::ActUpdate, 3'd4, 32'h0000_1000, 1'b1, '{3'd4, 16'd0, 1'b0, 1'b1}},
    '{ezs_pkg::ActUpdate, 3'd5, 32'h0000_1000, 1'b1, '{3'd5, 16'd0, 1'b0, 1'b1}},
    '{ezs_pkg::ActClear, 3'd6, 32'h1234_5678, 1'b1, '{3'd6, 16'd0, 1'b0, 1'b0}}
  };

  // One phase of random traffic: mostly steady series per channel with spikes
  task automatic random_phase(input int n);
    logic [ezs_pkg::ValW-1:0] base [ezs_pkg::NumChannels];
    int ch, p;
    logic [ezs_pkg::ValW-1:0] smp;
    for (int c = 0; c < ezs_pkg::NumChannels; c++) base[c] = $urandom;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(99) < 4 ? $urandom_range(7, 6) : $urandom_range(5);
      p = $urandom_range(99);
      if (ch < ezs_pkg::NumChannels) begin
        if (p < 60) smp = base[ch] + $urandom_range(64) - 32;
        else if (p < 75) smp = base[ch] + $urandom_range(4096) - 2048;
        else if (p < 90) smp = $urandom;
        else if (p < 95) smp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        else smp = base[ch] ^ (32'h1 << $urandom_range(31));
      end else begin
        smp = $urandom;
      end
      send_item($urandom_range(99) < 3 ? ezs_pkg::ActClear : ezs_pkg::ActUpdate,
                ch[ezs_pkg::ChanW-1:0], smp, 1'b1);
    end
  endtask

  initial begin
    score_res_t want;
    logic [15:0] cfg_sets [4][8];
    cfg_sets[0] = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd9830, 16'd6554, 16'd0, 16'd0};
    cfg_sets[1] = '{16'd65535, 16'd0, 16'd65535, 16'd1, 16'd200, 16'd60000, 16'h7FFF,
                    16'd255};
    cfg_sets[2] = '{16'd12000, 16'd3000, 16'd40000, 16'd500, 16'd20000, 16'd7000, 16'd256,
                    16'd2};
    cfg_sets[3] = '{16'd9830, 16'd9830, 16'd7864, 16'd7864, 16'd6554, 16'd6554, 16'd717,
                    16'd6};
    reset_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows after reset, defaults in force
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].chan, dir_rows[i].sample, 1'b0);
      if (dir_rows[i].has_res) begin
        want = pending_scores[$];
        if (want !== dir_rows[i].res) report($sformatf("table row %0d disagrees", i));
      end
    end
    drain();

    // Long receiver hold-off while the sender keeps offering
    long_stall_req = 1'b1;
    random_phase(20);
    drain();

    // Sweep register settings, extremes included
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 8; r++) write_reg(r[2:0], cfg_sets[k][r]);
      cfg_valid_i <= 1'b0;
      random_phase(330);
      drain();
    end

    $display("covered %0d results, %0d non-zero scores, %0d anomalies over 4 settings",
             n_results, n_scored, n_anomaly);
    if (errors == 0 && pending_scores.size() == 0)
      $display("ewma_zscore_anomaly_scorer_unit test passed");
    else
      $display("ewma_zscore_anomaly_scorer_unit test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ezs_pkg.sv
rtl/ezs_core.sv
rtl/ewma_zscore_anomaly_scorer_unit.sv
bench/ewma_zscore_anomaly_scorer_unit_tb.sv
